FILE: design/chs_pkg.sv
// ---------------------------------------------------------------------------
// Cuckoo hash table package
// Shared constants, request, configuration and bin types and the engine state encoding.
// ---------------------------------------------------------------------------
package chs_pkg;

    localparam int ITEMS      = 1024;
    localparam int MAX_HASHES = 4;
    localparam int HASH_W     = 64;
    localparam int IDX_W      = 10;
    localparam int HIDX_W     = 2;
    localparam int NH_W       = 3;
    localparam int NB_W       = 12;
    localparam int MT_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int USED_W     = 4;
    localparam int REM_W      = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES  = 2'd2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef struct packed {
        logic                                op;
        logic [IDX_W-1:0]                    item_index;
        logic [MAX_HASHES-1:0][HASH_W-1:0]   hash;
    } req_t;

    // effective configuration, hash count and bin count already saturated
    typedef struct packed {
        logic [NH_W-1:0] nh;
        logic [NB_W-1:0] nb;
        logic [MT_W-1:0] mt;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] item;
        logic [HIDX_W-1:0] hidx;
    } bin_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HWR,
        ST_TRY,
        ST_HWAIT,
        ST_AMOD,
        ST_BWAIT,
        ST_STASH,
        ST_FSEL,
        ST_FMOD,
        ST_FBIN,
        ST_SSEL,
        ST_CRD,
        ST_CCHK,
        ST_DONE
    } back_state_t;

endpackage

FILE: design/chs_ifs.sv
// ---------------------------------------------------------------------------
// Cuckoo hash table channel interfaces
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface chs_req_if;
    import chs_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  item_index;
    logic [HASH_W-1:0] hash_0;
    logic [HASH_W-1:0] hash_1;
    logic [HASH_W-1:0] hash_2;
    logic [HASH_W-1:0] hash_3;

    modport source (output valid, op, item_index, hash_0, hash_1, hash_2, hash_3,
                    input ready);
    modport sink   (input valid, op, item_index, hash_0, hash_1, hash_2, hash_3,
                    output ready);
endinterface

interface chs_rsp_if;
    import chs_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic              went_to_stash;
    logic              stash_overflow;
    logic [USED_W-1:0] stash_used;

    modport source (output valid, found, found_index, went_to_stash, stash_overflow,
                    stash_used, input ready);
    modport sink   (input valid, found, found_index, went_to_stash, stash_overflow,
                    stash_used, output ready);
endinterface

FILE: design/cuckoo_hash_table_with_stash_top.sv
// ---------------------------------------------------------------------------
// Cuckoo hash table with stash, top level
// Configuration registers, front queue and insert/find engine.
// ---------------------------------------------------------------------------
// After reset the block sweeps the bin table clean, one bin a cycle (BINS
// bins, 2048 by default), and takes no request until that is done. Every
// bin address is a 64-bit hash taken modulo bin_count in a shared bit-serial
// remainder unit. An insert takes the request, writes its hashes, then makes
// placement attempts (hash read, remainder, bin read and write) until a bin
// was empty or the tries run out, when the homeless entry goes to the stash
// if it has room, and posts the result. A find works each candidate bin
// (remainder, bin read, stored hashes compared in turn), then each stash
// entry in use likewise, stops at the first full match and posts the result.
// One request is worked at a time; a two-deep request queue and a result
// register decouple both sides, and a stalled result holds the engine.
module cuckoo_hash_table_with_stash_top
#(
    parameter int BINS        = 2048,
    parameter int STASH_DEPTH = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    chs_req_if.sink                          req,
    chs_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [chs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import chs_pkg::*;

    logic [NH_W-1:0] num_hashes_reg;
    logic [NB_W-1:0] bin_count_reg;
    logic [MT_W-1:0] max_tries_reg;
    cfg_t            cfg;
    req_t            q_data;
    logic            q_valid, q_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg <= NH_W'(2);
            bin_count_reg  <= NB_W'(2048);
            max_tries_reg  <= MT_W'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_HASHES: num_hashes_reg <= cfg_data[NH_W-1:0];
                CFG_BIN_COUNT:  bin_count_reg  <= cfg_data[NB_W-1:0];
                CFG_MAX_TRIES:  max_tries_reg  <= cfg_data[MT_W-1:0];
                default:        ;
            endcase
        end
    end

    // saturate to the ranges in use
    always_comb
    begin
        cfg.nh = num_hashes_reg;
        if (num_hashes_reg < NH_W'(2))
            cfg.nh = NH_W'(2);
        else if (num_hashes_reg > NH_W'(MAX_HASHES))
            cfg.nh = NH_W'(MAX_HASHES);
        cfg.nb = bin_count_reg;
        if (bin_count_reg == '0)
            cfg.nb = NB_W'(1);
        else if (32'(bin_count_reg) > BINS)
            cfg.nb = NB_W'(BINS);
        cfg.mt = max_tries_reg;
    end

    chs_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    chs_back
    #(
        .BINS        (BINS),
        .STASH_DEPTH (STASH_DEPTH)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .rsp     (rsp)
    );

endmodule

FILE: design/chs_front.sv
// ---------------------------------------------------------------------------
// Cuckoo hash table front end
// Accepts requests, packs them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module chs_front
(
    input  logic          clk,
    input  logic          rst_n,
    chs_req_if.sink       req,
    output chs_pkg::req_t q_data,
    output logic          q_valid,
    input  logic          q_ready
);
    import chs_pkg::*;

    req_t       fifo_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    req_t       packed_req;

    // pack the request fields
    always_comb
    begin
        packed_req.op         = req.op;
        packed_req.item_index = req.item_index;
        packed_req.hash[0]    = req.hash_0;
        packed_req.hash[1]    = req.hash_1;
        packed_req.hash[2]    = req.hash_2;
        packed_req.hash[3]    = req.hash_3;
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = fifo_reg[rptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = q_valid && q_ready;

    // queue pointers
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wptr_reg] <= packed_req;
    end

endmodule

FILE: design/chs_mod.sv
// ---------------------------------------------------------------------------
// Cuckoo hash table remainder unit
// Restoring remainder of a 64-bit value by a 12-bit divisor, one bit a cycle.
// ---------------------------------------------------------------------------
module chs_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [chs_pkg::HASH_W-1:0]    dividend,
    input  logic [chs_pkg::REM_W-1:0]     divisor,
    output logic                          done,
    output logic [chs_pkg::REM_W-1:0]     remainder
);
    import chs_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [HASH_W-1:0]   dvd_reg, dvd_next;
    logic [REM_W-1:0]    div_reg, div_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W:0]      trial;

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign trial     = {rem_reg, dvd_reg[HASH_W-1]};

    // one restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = REM_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[REM_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

endmodule

FILE: design/chs_back.sv
// ---------------------------------------------------------------------------
// Cuckoo hash table back end
// Runs inserts (eviction chain, stash) and finds (bin probe, stash scan).
// ---------------------------------------------------------------------------
module chs_back
#(
    parameter int BINS        = 2048,
    parameter int STASH_DEPTH = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  chs_pkg::cfg_t cfg,
    input  chs_pkg::req_t q_data,
    input  logic          q_valid,
    output logic          q_ready,
    chs_rsp_if.source     rsp
);
    import chs_pkg::*;

    localparam int HW    = $clog2(ITEMS);
    localparam int HSA_W = HW + HIDX_W;
    localparam int AW    = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int SCW   = $clog2(STASH_DEPTH + 1);
    localparam int SIW   = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;

    // memories
    logic [HASH_W-1:0] hs_mem [ITEMS * MAX_HASHES];
    bin_t              bt_mem [BINS];
    logic [IDX_W-1:0]  st_item_mem [STASH_DEPTH];
    logic [HIDX_W-1:0] st_hidx_mem [STASH_DEPTH];

    logic              hs_we;
    logic [HSA_W-1:0]  hs_waddr, hs_raddr;
    logic [HASH_W-1:0] hs_wdata, hs_rdata;
    logic              bt_we;
    logic [AW-1:0]     bt_waddr, bt_raddr;
    bin_t              bt_wdata, bt_rdata;
    logic              st_we;

    // remainder unit
    logic              mod_start, mod_done;
    logic [HASH_W-1:0] mod_dvd;
    logic [REM_W-1:0]  mod_div, mod_rem;

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [HIDX_W-1:0] hidx_reg, hidx_next;
    logic [MT_W-1:0]   t_reg, t_next;
    logic [NH_W-1:0]   j_reg, j_next;
    logic [NH_W-1:0]   k_reg, k_next;
    logic [SCW-1:0]    sj_reg, sj_next;
    logic [SCW-1:0]    scnt_reg, scnt_next;
    logic [IDX_W-1:0]  citem_reg, citem_next;
    logic              in_stash_reg, in_stash_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    logic              tost_reg, tost_next;
    logic              ovf_reg, ovf_next;
    logic              ovalid_reg, ovalid_next;
    logic              out_load;
    logic [NH_W-1:0]   hwrap;
    logic [NH_W-1:0]   hsum;

    chs_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (mod_div),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // next hash choice of an evicted entry, cyclic in nh
    always_comb
    begin
        hsum  = NH_W'(bt_rdata.hidx) + NH_W'(1);
        hwrap = hsum;
        if (hwrap >= cfg.nh)
            hwrap = hwrap - cfg.nh;
        if (hwrap >= cfg.nh)
            hwrap = hwrap - cfg.nh;
    end

    assign out_load = (state_reg == ST_DONE) && (!ovalid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == AW'(BINS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                    state_next = (q_data.op == OP_INSERT) ? ST_HWR : ST_FSEL;
            ST_HWR:
                if (j_reg + NH_W'(1) == cfg.nh)
                    state_next = ST_TRY;
            ST_TRY:
                state_next = (t_reg == cfg.mt) ? ST_STASH : ST_HWAIT;
            ST_HWAIT:
                state_next = ST_AMOD;
            ST_AMOD:
                if (mod_done)
                    state_next = ST_BWAIT;
            ST_BWAIT:
                state_next = bt_rdata.valid ? ST_TRY : ST_DONE;
            ST_STASH:
                state_next = ST_DONE;
            ST_FSEL:
                state_next = (j_reg < cfg.nh) ? ST_FMOD : ST_SSEL;
            ST_FMOD:
                if (mod_done)
                    state_next = ST_FBIN;
            ST_FBIN:
                state_next = bt_rdata.valid ? ST_CRD : ST_FSEL;
            ST_SSEL:
                state_next = (sj_reg < scnt_reg) ? ST_CRD : ST_DONE;
            ST_CRD:
                state_next = ST_CCHK;
            ST_CCHK:
                if (hs_rdata != req_reg.hash[k_reg[HIDX_W-1:0]])
                    state_next = in_stash_reg ? ST_SSEL : ST_FSEL;
                else if (k_reg + NH_W'(1) == cfg.nh)
                    state_next = ST_DONE;
                else
                    state_next = ST_CRD;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_next      = clr_reg;
        req_next      = req_reg;
        cur_next      = cur_reg;
        hidx_next     = hidx_reg;
        t_next        = t_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        sj_next       = sj_reg;
        scnt_next     = scnt_reg;
        citem_next    = citem_reg;
        in_stash_next = in_stash_reg;
        addr_next     = addr_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        tost_next     = tost_reg;
        ovf_next      = ovf_reg;
        ovalid_next   = ovalid_reg;
        q_ready       = 1'b0;
        hs_we         = 1'b0;
        hs_waddr      = {HW'(cur_reg), j_reg[HIDX_W-1:0]};
        hs_wdata      = req_reg.hash[j_reg[HIDX_W-1:0]];
        hs_raddr      = {HW'(cur_reg), hidx_reg};
        bt_we         = 1'b0;
        bt_waddr      = addr_reg;
        bt_wdata      = '{valid: 1'b1, item: cur_reg, hidx: hidx_reg};
        bt_raddr      = AW'(mod_rem);
        st_we         = 1'b0;
        mod_start     = 1'b0;
        mod_dvd       = hs_rdata;
        mod_div       = cfg.nb;

        if (rsp.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                bt_we    = 1'b1;
                bt_waddr = clr_reg;
                bt_wdata = '0;
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    req_next   = q_data;
                    found_next = 1'b0;
                    fidx_next  = '0;
                    tost_next  = 1'b0;
                    ovf_next   = 1'b0;
                    j_next     = '0;
                    // item index already lies within the item range
                    cur_next   = q_data.item_index;
                end
            end
            ST_HWR:
            begin
                hs_we  = 1'b1;
                j_next = j_reg + NH_W'(1);
                hidx_next = '0;
                t_next    = '0;
            end
            ST_TRY:
                ;
            ST_HWAIT:
            begin
                mod_start = 1'b1;
                mod_dvd   = hs_rdata;
                mod_div   = cfg.nb;
            end
            ST_AMOD:
                if (mod_done)
                    addr_next = AW'(mod_rem);
            ST_BWAIT:
            begin
                bt_we = 1'b1;
                if (bt_rdata.valid)
                begin
                    cur_next  = bt_rdata.item;
                    hidx_next = hwrap[HIDX_W-1:0];
                    t_next    = t_reg + MT_W'(1);
                end
            end
            ST_STASH:
                if (scnt_reg < SCW'(STASH_DEPTH))
                begin
                    st_we     = 1'b1;
                    scnt_next = scnt_reg + SCW'(1);
                    tost_next = 1'b1;
                end
                else
                    ovf_next = 1'b1;
            ST_FSEL:
            begin
                sj_next = '0;
                if (j_reg < cfg.nh)
                begin
                    mod_start = 1'b1;
                    mod_dvd   = req_reg.hash[j_reg[HIDX_W-1:0]];
                    mod_div   = cfg.nb;
                end
            end
            ST_FMOD:
                ;
            ST_FBIN:
            begin
                k_next = '0;
                if (bt_rdata.valid)
                begin
                    citem_next    = bt_rdata.item;
                    in_stash_next = 1'b0;
                end
                else
                    j_next = j_reg + NH_W'(1);
            end
            ST_SSEL:
            begin
                k_next        = '0;
                citem_next    = st_item_mem[sj_reg[SIW-1:0]];
                in_stash_next = 1'b1;
            end
            ST_CRD:
                hs_raddr = {HW'(citem_reg), k_reg[HIDX_W-1:0]};
            ST_CCHK:
                if (hs_rdata != req_reg.hash[k_reg[HIDX_W-1:0]])
                begin
                    if (in_stash_reg)
                        sj_next = sj_reg + SCW'(1);
                    else
                        j_next = j_reg + NH_W'(1);
                end
                else if (k_reg + NH_W'(1) == cfg.nh)
                begin
                    found_next = 1'b1;
                    fidx_next  = citem_reg;
                end
                else
                    k_next = k_reg + NH_W'(1);
            ST_DONE:
                if (out_load)
                    ovalid_next = 1'b1;
            default:
                ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            scnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            scnt_reg   <= scnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cur_reg      <= cur_next;
        hidx_reg     <= hidx_next;
        t_reg        <= t_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        sj_reg       <= sj_next;
        citem_reg    <= citem_next;
        in_stash_reg <= in_stash_next;
        addr_reg     <= addr_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        tost_reg     <= tost_next;
        ovf_reg      <= ovf_next;
        if (out_load)
        begin
            rsp.found          <= found_reg;
            rsp.found_index    <= fidx_reg;
            rsp.went_to_stash  <= tost_reg;
            rsp.stash_overflow <= ovf_reg;
            rsp.stash_used     <= USED_W'(scnt_reg);
        end
    end

    assign rsp.valid = ovalid_reg;

    // hash store
    always_ff @(posedge clk)
    begin
        if (hs_we)
            hs_mem[hs_waddr] <= hs_wdata;
        hs_rdata <= hs_mem[hs_raddr];
    end

    // bin table
    always_ff @(posedge clk)
    begin
        if (bt_we)
            bt_mem[bt_waddr] <= bt_wdata;
        bt_rdata <= bt_mem[bt_raddr];
    end

    // stash
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_item_mem[scnt_reg[SIW-1:0]] <= cur_reg;
            st_hidx_mem[scnt_reg[SIW-1:0]] <= hidx_reg;
        end
    end

endmodule
